### design/assert_macros.svh
// Assertion macros used by the densifier checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property disabled while reset is high
`define RWD_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("rwd assertion failed");

// Clocked property checked during reset as well
`define RWD_ASSERT_RST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("rwd reset check failed");

`endif

### design/rwd_pkg.sv
// Package for the route waypoint densifier: widths, option codes, register map,
// measure-unit handshake structs and a magnitude helper. No dependencies.
package rwd_pkg;

  localparam int MAX_RUN = 32;
  localparam int N_MAX   = (MAX_RUN > 5) ? MAX_RUN : 5;
  localparam int N_W     = $clog2(N_MAX + 1);
  localparam int R_W     = N_W + 2;

  localparam int CW      = 24;
  localparam int DW      = CW + 1;
  localparam int MAG_W   = CW;
  localparam int RT_W    = MAG_W + 1;
  localparam int SQ_W    = 2 * RT_W;
  localparam int REM_W   = RT_W + 4;
  localparam int STEP_W  = $clog2(RT_W + 1);
  localparam int SP_W    = 16;
  localparam int OPT_W   = 4;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [SP_W-1:0] SPACING_RESET = 16'd512;
  localparam logic            REG_SPACING   = 1'b0;

  localparam logic [OPT_W-1:0] OPT_LINE_A  = 4'd3;
  localparam logic [OPT_W-1:0] OPT_LINE_B  = 4'd4;
  localparam logic [OPT_W-1:0] OPT_CURVE_A = 4'd5;
  localparam logic [OPT_W-1:0] OPT_CURVE_B = 4'd6;

  localparam logic [N_W-1:0] CURVE_N   = N_W'(4);
  localparam logic [N_W-1:0] CURVE_PTS = N_W'(5);

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
  } meas_req_t;

  typedef struct packed {
    logic           done;
    logic [N_W-1:0] n;
  } meas_res_t;

  // magnitude of a segment delta (never exceeds MAG_W bits)
  function automatic logic [MAG_W-1:0] abs_mag(input logic [DW-1:0] d);
    logic [DW-1:0] neg;
    neg = -d;
    return d[DW-1] ? neg[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

endpackage

### design/rwd_if.sv
// Stream interfaces of the densifier: waypoints in, points out.
// Depends on rwd_pkg.
interface rwd_wp_if import rwd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CW-1:0]    pos_x;
  logic [CW-1:0]    pos_y;
  logic [OPT_W-1:0] road_option;
  logic             route_end;

  modport source (output valid, pos_x, pos_y, road_option, route_end, input ready);
  modport sink   (input valid, pos_x, pos_y, road_option, route_end, output ready);
endinterface

interface rwd_pt_if import rwd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CW-1:0]    out_x;
  logic [CW-1:0]    out_y;
  logic [OPT_W-1:0] out_option;
  logic             run_last;

  modport source (output valid, out_x, out_y, out_option, run_last, input ready);
  modport sink   (input valid, out_x, out_y, out_option, run_last, output ready);
endinterface

### design/route_waypoint_densifier_core.sv
// Route waypoint densifier top level: waypoint state, segment sequencer,
// bit-serial divider and point stepper. Depends on rwd_pkg, rwd_if, rwd_measure.
//
//  channel | dir | transfer when        | payload
//  wp      | in  | valid && ready       | pos_x, pos_y, road_option, route_end
//  pt      | out | valid && ready       | out_x, out_y, out_option, run_last
//  apb     | in  | psel&penable&pwrite  | point_spacing at byte address 0
//
// A waypoint that emits nothing is taken in the idle state; a measured segment adds the
// start, squares, root, count (up to MAX_RUN spacings) and hand-off steps.
// Each run then passes the serial divider and emits one point per cycle unless pt stalls.
// wp.ready is high only while the sequencer is idle. A stalled pt holds its
// register and the stepper waits. Reset clears waypoint state and spacing to 2.0.
module route_waypoint_densifier_core import rwd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rwd_wp_if.sink            wp,
  rwd_pt_if.source          pt,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {S_IDLE, S_MEAS, S_DLOAD, S_DIV, S_FIX, S_EMIT} state_t;

  state_t            state;
  logic [SP_W-1:0]   spacing;

  // waypoint history
  logic [CW-1:0]     older_x, older_y, newer_x, newer_y;
  logic [OPT_W-1:0]  older_opt, newer_opt;
  logic              held, pending;

  // measured segment (linear run or curve tail)
  logic [CW-1:0]     m_x, m_y;
  logic [DW-1:0]     m_dx, m_dy;
  logic [OPT_W-1:0]  m_opt;
  logic              tail_mode, meas_go;
  logic              tail_pend;
  logic [N_W-1:0]    tail_n;

  // current run
  logic [CW-1:0]     seg_x, seg_y;
  logic [DW-1:0]     del_x, del_y;
  logic [OPT_W-1:0]  seg_opt;
  logic [N_W-1:0]    div_n, pts;

  // divider and stepper
  logic [MAG_W-1:0]  dsx, dsy;
  logic [N_W-1:0]    rx, ry;
  logic              negx, negy;
  logic [STEP_W-1:0] dstep;
  logic [DW-1:0]     stq_x, stq_y;
  logic [R_W-1:0]    r2x, r2y, racc_x, racc_y;
  logic [CW-1:0]     pt_x, pt_y;

  // output register
  logic              ovalid, o_last;
  logic [CW-1:0]     o_x, o_y;
  logic [OPT_W-1:0]  o_opt;

  meas_req_t         mreq;
  meas_res_t         mres;

  logic [DW-1:0]     in_dx, in_dy, cur_dx, cur_dy;
  logic              nz, is_line, is_curve;
  logic [N_W:0]      rsh_x, rsh_y;
  logic              gex, gey;
  logic [DW-1:0]     qx_ext, qy_ext, qx_neg, qy_neg, fix_qx, fix_qy;
  logic [R_W-1:0]    fix_rx, fix_ry, twon, sum_x, sum_y;
  logic              cx, cy, can_load;
  logic [N_W-1:0]    meas_n;

  // segment deltas and option decode
  always_comb begin
    in_dx    = {wp.pos_x[CW-1], wp.pos_x} - {newer_x[CW-1], newer_x};
    in_dy    = {wp.pos_y[CW-1], wp.pos_y} - {newer_y[CW-1], newer_y};
    cur_dx   = {newer_x[CW-1], newer_x} - {older_x[CW-1], older_x};
    cur_dy   = {newer_y[CW-1], newer_y} - {older_y[CW-1], older_y};
    nz       = (in_dx != '0) || (in_dy != '0);
    is_line  = (newer_opt == OPT_LINE_A) || (newer_opt == OPT_LINE_B);
    is_curve = (newer_opt == OPT_CURVE_A) || (newer_opt == OPT_CURVE_B);
    meas_n   = (mres.n > N_W'(1)) ? mres.n : N_W'(1);
  end

  // divider step and floor fixup
  always_comb begin
    rsh_x  = {rx, dsx[MAG_W-1]};
    rsh_y  = {ry, dsy[MAG_W-1]};
    gex    = rsh_x >= {1'b0, div_n};
    gey    = rsh_y >= {1'b0, div_n};
    qx_ext = {1'b0, dsx};
    qy_ext = {1'b0, dsy};
    qx_neg = -qx_ext;
    qy_neg = -qy_ext;
    fix_qx = !negx ? qx_ext : ((rx == '0) ? qx_neg : qx_neg - 1'b1);
    fix_qy = !negy ? qy_ext : ((ry == '0) ? qy_neg : qy_neg - 1'b1);
    fix_rx = (negx && rx != '0) ? {1'b0, div_n - rx, 1'b0} : {1'b0, rx, 1'b0};
    fix_ry = (negy && ry != '0) ? {1'b0, div_n - ry, 1'b0} : {1'b0, ry, 1'b0};
  end

  // point stepper: remainder accumulates against 2n
  always_comb begin
    twon     = {1'b0, div_n, 1'b0};
    sum_x    = racc_x + r2x;
    sum_y    = racc_y + r2y;
    cx       = sum_x >= twon;
    cy       = sum_y >= twon;
    can_load = !ovalid || pt.ready;
  end

  assign mreq.start = meas_go;
  assign mreq.dx    = m_dx;
  assign mreq.dy    = m_dy;

  rwd_measure u_meas (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .spacing (spacing),
    .res     (mres)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (psel && penable && pwrite && paddr[APB_AW-1:2] == REG_SPACING) begin
      spacing <= pwdata[SP_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1:2] == REG_SPACING) ? APB_DW'(spacing) : '0;
  assign pready = 1'b1;

  // sequencer, waypoint state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= 1'b0;
      pending   <= 1'b0;
      older_x   <= '0;
      older_y   <= '0;
      older_opt <= '0;
      newer_x   <= '0;
      newer_y   <= '0;
      newer_opt <= '0;
      meas_go   <= 1'b0;
      tail_pend <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      meas_go <= 1'b0;
      if (pt.valid && pt.ready) ovalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (wp.valid) begin
            // pick the work for this waypoint
            if (pending) begin
              seg_x     <= older_x;
              seg_y     <= older_y;
              del_x     <= cur_dx;
              del_y     <= cur_dy;
              div_n     <= CURVE_N;
              pts       <= CURVE_PTS;
              seg_opt   <= older_opt;
              m_x       <= newer_x;
              m_y       <= newer_y;
              m_dx      <= in_dx;
              m_dy      <= in_dy;
              tail_mode <= 1'b1;
              meas_go   <= 1'b1;
              state     <= S_MEAS;
            end else if (held && nz) begin
              if (is_line) begin
                m_x       <= newer_x;
                m_y       <= newer_y;
                m_dx      <= in_dx;
                m_dy      <= in_dy;
                m_opt     <= newer_opt;
                tail_mode <= 1'b0;
                meas_go   <= 1'b1;
                state     <= S_MEAS;
              end else if (is_curve) begin
                if (wp.route_end) begin
                  seg_x     <= newer_x;
                  seg_y     <= newer_y;
                  del_x     <= in_dx;
                  del_y     <= in_dy;
                  div_n     <= CURVE_N;
                  pts       <= CURVE_PTS;
                  seg_opt   <= newer_opt;
                  tail_pend <= 1'b0;
                  state     <= S_DLOAD;
                end
              end else begin
                seg_x     <= newer_x;
                seg_y     <= newer_y;
                del_x     <= in_dx;
                del_y     <= in_dy;
                div_n     <= N_W'(1);
                pts       <= N_W'(1);
                seg_opt   <= newer_opt;
                tail_pend <= 1'b0;
                state     <= S_DLOAD;
              end
            end

            // update waypoint history
            if (!pending && held && nz && is_curve && !wp.route_end) begin
              older_x   <= newer_x;
              older_y   <= newer_y;
              older_opt <= newer_opt;
              newer_x   <= wp.pos_x;
              newer_y   <= wp.pos_y;
              newer_opt <= wp.road_option;
              pending   <= 1'b1;
            end else if (wp.route_end) begin
              older_x   <= '0;
              older_y   <= '0;
              older_opt <= '0;
              newer_x   <= '0;
              newer_y   <= '0;
              newer_opt <= '0;
              held      <= 1'b0;
              pending   <= 1'b0;
            end else begin
              newer_x   <= wp.pos_x;
              newer_y   <= wp.pos_y;
              newer_opt <= wp.road_option;
              held      <= 1'b1;
              pending   <= 1'b0;
            end
          end
        end
        S_MEAS: begin
          if (mres.done) begin
            if (tail_mode) begin
              tail_pend <= mres.n > N_W'(1);
              tail_n    <= mres.n;
            end else begin
              seg_x     <= m_x;
              seg_y     <= m_y;
              del_x     <= m_dx;
              del_y     <= m_dy;
              seg_opt   <= m_opt;
              div_n     <= meas_n;
              pts       <= meas_n;
              tail_pend <= 1'b0;
            end
            state <= S_DLOAD;
          end
        end
        S_DLOAD: begin
          dsx   <= abs_mag(del_x);
          dsy   <= abs_mag(del_y);
          negx  <= del_x[DW-1];
          negy  <= del_y[DW-1];
          rx    <= '0;
          ry    <= '0;
          dstep <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle on each axis
          dsx   <= {dsx[MAG_W-2:0], gex};
          dsy   <= {dsy[MAG_W-2:0], gey};
          rx    <= gex ? N_W'(rsh_x - {1'b0, div_n}) : rsh_x[N_W-1:0];
          ry    <= gey ? N_W'(rsh_y - {1'b0, div_n}) : rsh_y[N_W-1:0];
          dstep <= dstep + 1'b1;
          if (dstep == STEP_W'(MAG_W - 1)) state <= S_FIX;
        end
        S_FIX: begin
          stq_x  <= fix_qx;
          stq_y  <= fix_qy;
          r2x    <= fix_rx;
          r2y    <= fix_ry;
          racc_x <= R_W'(div_n);
          racc_y <= R_W'(div_n);
          pt_x   <= seg_x;
          pt_y   <= seg_y;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (can_load) begin
            o_x    <= pt_x;
            o_y    <= pt_y;
            o_opt  <= seg_opt;
            o_last <= (pts == N_W'(1)) && !tail_pend;
            ovalid <= 1'b1;
            pt_x   <= pt_x + stq_x[CW-1:0] + CW'(cx);
            pt_y   <= pt_y + stq_y[CW-1:0] + CW'(cy);
            racc_x <= cx ? sum_x - twon : sum_x;
            racc_y <= cy ? sum_y - twon : sum_y;
            pts    <= pts - 1'b1;
            if (pts == N_W'(1)) begin
              if (tail_pend) begin
                seg_x     <= m_x;
                seg_y     <= m_y;
                del_x     <= m_dx;
                del_y     <= m_dy;
                seg_opt   <= OPT_LINE_B;
                div_n     <= tail_n;
                pts       <= tail_n;
                tail_pend <= 1'b0;
                state     <= S_DLOAD;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign wp.ready      = (state == S_IDLE);
  assign pt.valid      = ovalid;
  assign pt.out_x      = o_x;
  assign pt.out_y      = o_y;
  assign pt.out_option = o_opt;
  assign pt.run_last   = o_last;

endmodule

### design/rwd_measure.sv
// Segment run-length unit: bit-serial squares, digit-serial square root,
// then counting spacings up to MAX_RUN. Depends on rwd_pkg.
module rwd_measure import rwd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  meas_req_t       req,
  input  logic [SP_W-1:0] spacing,
  output meas_res_t       res
);

  typedef enum logic [1:0] {M_IDLE, M_SQ, M_RT, M_CNT} mstate_t;

  mstate_t           state;
  logic [MAG_W-1:0]  mx, my;
  logic [SQ_W-1:0]   ax, ay, acc;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [RT_W-1:0]   root;
  logic [N_W-1:0]    cnt;
  logic [RT_W:0]     cacc;
  logic              done;

  logic [SP_W-1:0]   sp_eff;
  logic [SQ_W-1:0]   acc_next;
  logic [REM_W-1:0]  rem_sh, trial;
  logic              ge, cnt_go;

  // datapath for one step of each phase
  always_comb begin
    sp_eff   = (spacing == '0) ? SP_W'(1) : spacing;
    acc_next = acc + (mx[0] ? ax : '0) + (my[0] ? ay : '0);
    rem_sh   = {rem[REM_W-3:0], acc[SQ_W-1 -: 2]};
    trial    = {{(REM_W-RT_W-2){1'b0}}, root, 2'b01};
    ge       = rem_sh >= trial;
    cnt_go   = (cnt < N_W'(MAX_RUN)) && (cacc <= {1'b0, root});
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            mx    <= abs_mag(req.dx);
            my    <= abs_mag(req.dy);
            ax    <= SQ_W'(abs_mag(req.dx));
            ay    <= SQ_W'(abs_mag(req.dy));
            acc   <= '0;
            step  <= '0;
            state <= M_SQ;
          end
        end
        M_SQ: begin
          acc  <= acc_next;
          ax   <= ax << 1;
          ay   <= ay << 1;
          mx   <= mx >> 1;
          my   <= my >> 1;
          step <= step + 1'b1;
          if (step == STEP_W'(MAG_W - 1)) begin
            step  <= '0;
            rem   <= '0;
            root  <= '0;
            state <= M_RT;
          end
        end
        M_RT: begin
          rem  <= ge ? (rem_sh - trial) : rem_sh;
          root <= {root[RT_W-2:0], ge};
          acc  <= acc << 2;
          step <= step + 1'b1;
          if (step == STEP_W'(RT_W - 1)) begin
            cnt   <= '0;
            cacc  <= (RT_W+1)'(sp_eff);
            state <= M_CNT;
          end
        end
        M_CNT: begin
          if (cnt_go) begin
            cnt  <= cnt + 1'b1;
            cacc <= cacc + (RT_W+1)'(sp_eff);
          end else begin
            done  <= 1'b1;
            state <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign res.done = done;
  assign res.n    = cnt;

endmodule

### design/rwd_checker.sv
// Port-level checker for the densifier top level, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rwd_checker (
  input logic clk,
  input logic rst,
  input logic wp_ready,
  input logic pt_valid,
  input logic pt_ready,
  input logic pt_last
);

  // a stalled point stays offered
  `RWD_ASSERT(a_pt_hold, clk, rst, pt_valid && !pt_ready |=> pt_valid)

  // no new waypoint while a point short of the run's end is pending
  `RWD_ASSERT(a_busy_mid_run, clk, rst, pt_valid && !pt_last |-> !wp_ready)

  // reset empties the output register
  `RWD_ASSERT_RST(a_rst_empty, clk, rst |=> !pt_valid)

endmodule

bind route_waypoint_densifier_core rwd_checker u_rwd_checker (
  .clk      (clk),
  .rst      (rst),
  .wp_ready (wp.ready),
  .pt_valid (pt.valid),
  .pt_ready (pt.ready),
  .pt_last  (pt.run_last)
);

### sim/route_waypoint_densifier_core_tb.sv
// Testbench for route_waypoint_densifier_core: drives waypoints and spacing writes,
// predicts the densified point stream and checks every point in order.
// Depends on rwd_pkg, rwd_if and the core.
module route_waypoint_densifier_core_tb import rwd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [OPT_W-1:0] opt;
    logic             last;
  } point_t;

  // Densifier state mirror and expected point queue
  class densify_board;
    logic [SP_W-1:0]  spacing;
    longint           old_x, old_y, new_x, new_y;
    logic [OPT_W-1:0] old_opt, new_opt;
    int               held;
    bit               curve_wait;
    point_t           pending_pts[$];
    int               errors;

    function void clear();
      spacing = SPACING_RESET;
      old_x = 0; old_y = 0; new_x = 0; new_y = 0;
      old_opt = '0; new_opt = '0;
      held = 0; curve_wait = 0;
    endfunction

    function longint int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function int seg_count(longint dx, longint dy);
      longint unsigned s, n;
      s = (spacing == 0) ? 1 : spacing;
      n = int_root(dx * dx + dy * dy) / s;
      return (n > MAX_RUN) ? MAX_RUN : int'(n);
    endfunction

    function longint interp(longint a, longint d, longint j, longint n);
      longint num, q;
      num = 2 * j * d + n;
      q = num / (2 * n);
      if ((num % (2 * n)) != 0 && num < 0) q--;
      return a + q;
    endfunction

    function void push_pt(longint x, longint y, logic [OPT_W-1:0] o);
      point_t p;
      p.x = x[CW-1:0]; p.y = y[CW-1:0]; p.opt = o; p.last = 0;
      pending_pts = {pending_pts, p};
    endfunction

    function void push_run(longint x, longint y, longint dx, longint dy, int n,
                           logic [OPT_W-1:0] o);
      for (int j = 0; j < n; j++) push_pt(interp(x, dx, j, n), interp(y, dy, j, n), o);
    endfunction

    // Five curve points at quarters of the segment, both ends included
    function void push_curve();
      for (int j = 0; j <= 4; j++)
        push_pt(interp(old_x, new_x - old_x, j, 4), interp(old_y, new_y - old_y, j, 4),
                old_opt);
    endfunction

    // Note an accepted waypoint and queue the points it causes
    function void note_waypoint(logic [CW-1:0] px, logic [CW-1:0] py,
                                logic [OPT_W-1:0] o, logic e);
      longint x, y, dx, dy;
      int queued, n;
      x = longint'($signed(px)); y = longint'($signed(py));
      queued = pending_pts.size();
      dx = x - new_x; dy = y - new_y;
      if (curve_wait) begin
        n = seg_count(dx, dy);
        push_curve();
        if (n > 1) push_run(new_x, new_y, dx, dy, n, OPT_LINE_B);
      end else if (held != 0 && (dx != 0 || dy != 0)) begin
        if (new_opt == OPT_LINE_A || new_opt == OPT_LINE_B) begin
          n = seg_count(dx, dy);
          if (n > 1) push_run(new_x, new_y, dx, dy, n, new_opt);
          else push_pt(new_x, new_y, new_opt);
        end else if (new_opt == OPT_CURVE_A || new_opt == OPT_CURVE_B) begin
          old_x = new_x; old_y = new_y; old_opt = new_opt;
          new_x = x; new_y = y; new_opt = o;
          held = 2; curve_wait = 1;
          if (!e) return;
          push_curve();
        end else push_pt(new_x, new_y, new_opt);
      end
      new_x = x; new_y = y; new_opt = o; held = 1; curve_wait = 0;
      if (e) begin
        old_x = 0; old_y = 0; new_x = 0; new_y = 0;
        old_opt = '0; new_opt = '0; held = 0;
      end
      if (pending_pts.size() > queued) pending_pts[$].last = 1;
    endfunction

    function void report(string what, point_t got, point_t want);
      $display("MISMATCH %s: got %h/%h/%h/%b want %h/%h/%h/%b", what,
               got.x, got.y, got.opt, got.last, want.x, want.y, want.opt, want.last);
      errors++;
    endfunction

    // Compare an emitted point with the oldest expectation
    function void check_point(point_t got);
      point_t want;
      if (pending_pts.size() == 0) begin
        report("unexpected point", got, '0);
        return;
      end
      want = pending_pts.pop_front();
      if (got.x !== want.x) report("out_x", got, want);
      if (got.y !== want.y) report("out_y", got, want);
      if (got.opt !== want.opt) report("out_option", got, want);
      if (got.last !== want.last) report("run_last", got, want);
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic pready;
  rwd_wp_if wp();
  rwd_pt_if pt();
  densify_board board;
  longint cycles;
  bit hold_off;

  route_waypoint_densifier_core dut (
    .clk(clk), .rst(rst), .wp(wp.sink), .pt(pt.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("route_waypoint_densifier_core verification failed");
      $finish;
    end
  end

  // Point checker
  always @(posedge clk) begin
    if (!rst && pt.valid && pt.ready)
      board.check_point({pt.out_x, pt.out_y, pt.out_option, pt.run_last});
  end

  // Receiver stall pattern, with one long hold-off on request
  initial begin
    pt.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) pt.ready <= 0;
      else if (cycles % 400 < 120) pt.ready <= 1;
      else pt.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_spacing(logic [SP_W-1:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= '0; pwdata <= APB_DW'(v);
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.spacing = v;
  endtask

  // Offer one waypoint, held until transferred
  task automatic send_waypoint(logic [CW-1:0] x, logic [CW-1:0] y,
                               logic [OPT_W-1:0] o, logic e);
    wp.valid <= 1; wp.pos_x <= x; wp.pos_y <= y;
    wp.road_option <= o; wp.route_end <= e;
    do @(posedge clk); while (!wp.ready);
    board.note_waypoint(x, y, o, e);
    @(negedge clk);
  endtask

  task automatic gap();
    if ($urandom_range(0, 3) == 0) begin
      wp.valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    wp.valid <= 0;
    while (board.pending_pts.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  // Random route: mostly short coherent segments, some noise
  task automatic random_route(int len, int reach);
    logic [CW-1:0] x, y;
    x = CW'($urandom); y = CW'($urandom);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        x = CW'($urandom); y = CW'($urandom);
      end else if ($urandom_range(0, 12) != 0) begin
        x = x + CW'($urandom_range(0, 2 * reach) - reach);
        y = y + CW'($urandom_range(0, 2 * reach) - reach);
      end
      send_waypoint(x, y, ($urandom_range(0, 2) == 0) ? 4'($urandom) :
                    4'($urandom_range(3, 6)), (i == len - 1));
      gap();
    end
  endtask

  initial begin
    int sent;
    board = new();
    board.clear();
    board.errors = 0;
    cycles = 0; hold_off = 0;
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    wp.valid = 0; wp.pos_x = '0; wp.pos_y = '0; wp.road_option = '0; wp.route_end = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: every named option, extremes, identical points, curve with and without tail
    send_waypoint(24'h000000, 24'h000000, OPT_LINE_A, 1);
    send_waypoint(24'h000000, 24'h000000, OPT_LINE_A, 0);
    send_waypoint(24'h000000, 24'h000000, OPT_LINE_B, 0);
    send_waypoint(24'h000A00, 24'h000300, OPT_LINE_B, 0);
    send_waypoint(24'h000B00, 24'h000300, OPT_CURVE_A, 0);
    send_waypoint(24'h001B00, 24'hFFF000, 4'd0, 0);
    send_waypoint(24'h002000, 24'h000000, OPT_CURVE_B, 0);
    send_waypoint(24'h002000, 24'h000400, 4'd7, 0);
    send_waypoint(24'h002000, 24'h000400, 4'd15, 0);
    send_waypoint(24'h7FFFFF, 24'h800000, OPT_LINE_A, 0);
    send_waypoint(24'h800000, 24'h7FFFFF, OPT_CURVE_A, 0);
    send_waypoint(24'h800100, 24'h7FFF00, OPT_LINE_B, 1);
    send_waypoint(24'h000100, 24'h000200, OPT_CURVE_B, 0);
    send_waypoint(24'h001000, 24'h000200, 4'd2, 1);
    send_waypoint(24'h000000, 24'h000000, OPT_CURVE_A, 0);
    send_waypoint(24'h000400, 24'h000000, OPT_LINE_A, 0);
    send_waypoint(24'h000400, 24'h000000, 4'd1, 0);
    send_waypoint(24'hFFFFFF, 24'hFFFFFF, 4'd8, 1);
    drain();

    write_spacing(16'd1);
    send_waypoint(24'h000000, 24'h000000, OPT_LINE_A, 0);
    send_waypoint(24'h000005, 24'hFFFFFD, OPT_LINE_B, 0);
    send_waypoint(24'h0000FF, 24'h000000, 4'd0, 1);
    drain();

    // Random phases over several spacings
    sent = 21;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_spacing(16'd0);
        1: write_spacing(16'd65535);
        2: write_spacing(16'd1);
        3: write_spacing(16'd512);
        4: write_spacing(16'($urandom_range(1, 65535)));
        default: write_spacing(16'd128);
      endcase
      while (sent < 21 + (ph + 1) * 55) begin
        int len;
        len = $urandom_range(1, 9);
        random_route(len, (ph == 1) ? 8000000 : 6000);
        sent += len;
      end
      if (ph == 2) begin
        // Long receiver hold-off while waypoints keep coming
        hold_off = 1;
        fork
          random_route(6, 4000);
          begin
            repeat (1500) @(negedge clk);
            hold_off = 0;
          end
        join
        sent += 6;
      end
      drain();
    end

    if (board.errors == 0 && board.pending_pts.size() == 0)
      $display("route_waypoint_densifier_core verification clean");
    else begin
      if (board.pending_pts.size() != 0)
        $display("MISMATCH %0d points never emitted", board.pending_pts.size());
      $display("route_waypoint_densifier_core verification failed");
    end
    $finish;
  end
endmodule
